[rtl/fts_pkg.sv]
// Shared types and constants for the fixed-timestep scheduler
`timescale 1ns / 1ps
package fts_pkg;

    // fixed-point formats
    localparam int TIME_FRAC_BITS  = 24;
    localparam int SCALE_FRAC_BITS = 12;
    localparam int ALPHA_FRAC_BITS = 12;
    localparam int ALPHA_W         = 16;
    localparam int FPS_FRAC_BITS   = 8;
    localparam int FPS_W           = 24;

    // field and state widths
    localparam int DELTA_W  = 32;
    localparam int SCALE_W  = 15;
    localparam int SV_W     = 16;
    localparam int TOTAL_W  = 64;
    localparam int ACCUM_W  = 40;
    localparam int FRAMES_W = 32;
    localparam int PERIOD_W = 24;
    localparam int STEPS_W  = 4;
    localparam int PROD_W   = DELTA_W + SCALE_W;

    // serial divider sizing
    localparam int DIV_W     = 40;
    localparam int DIV_BITS  = 24;
    localparam int DIV_CNT_W = 5;

    // fps numerator is frames shifted so that the 24-bit quotient check is one compare
    localparam int FPS_NUM_W  = 48;
    localparam int FPS_SHIFT  = TIME_FRAC_BITS + FPS_FRAC_BITS - FPS_W;
    // alpha saturation compares the accumulator against the period shifted by this
    localparam int ALPHA_SHIFT = ALPHA_W - ALPHA_FRAC_BITS;

    localparam logic [ACCUM_W-1:0] WINDOW_ONE = ACCUM_W'(1) << TIME_FRAC_BITS;
    localparam logic [SCALE_W-1:0] SCALE_ONE  = SCALE_W'(1) << SCALE_FRAC_BITS;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd279620;
    localparam logic [STEPS_W-1:0]  MAX_STEPS_RESET = 4'd5;

    // opcodes
    localparam logic [2:0] OP_FRAME  = 3'd0;
    localparam logic [2:0] OP_SCALE  = 3'd1;
    localparam logic [2:0] OP_PAUSE  = 3'd2;
    localparam logic [2:0] OP_RESUME = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS   = 4'd1;

    typedef struct packed {
        logic [2:0]              opcode;
        logic [DELTA_W-1:0]      frame_delta;
        logic signed [SV_W-1:0]  scale_value;
    } t_in_item;

    typedef struct packed {
        logic [STEPS_W-1:0]  step_count;
        logic [ALPHA_W-1:0]  alpha;
        logic [FPS_W-1:0]    fps_value;
        logic [DELTA_W-1:0]  scaled_delta;
        logic [TOTAL_W-1:0]  real_total;
        logic [TOTAL_W-1:0]  game_total;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ACC,
        S_WINDOW,
        S_FPS_RUN,
        S_STEP,
        S_ALPHA_RUN,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic acc;
        logic fps_load;
        logic fps_wr;
        logic step;
        logic alpha_load;
        logic alpha_wr;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_frame;
        logic window_full;
        logic step_go;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

[rtl/fts_div.sv]
// Restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
module fts_div
    import fts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [DIV_W-1:0]     i_rem0,
    input  logic [DIV_W-1:0]     i_den,
    input  logic [DIV_BITS-1:0]  i_bits,
    input  logic [DIV_CNT_W-1:0] i_iters,
    output logic [DIV_BITS-1:0]  o_quo,
    output logic                 o_done
);

    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_den;
    logic [DIV_BITS-1:0]  r_bits;
    logic [DIV_BITS-1:0]  r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [DIV_W:0] w_trial;
    logic [DIV_W:0] w_diff;
    logic           w_ge;

    // one trial subtraction
    assign w_trial = {r_rem, r_bits[DIV_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};

    // iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_iters;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= i_rem0;
            r_den  <= i_den;
            r_bits <= i_bits;
            r_quo  <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            r_bits <= {r_bits[DIV_BITS-2:0], 1'b0};
            r_quo  <= {r_quo[DIV_BITS-2:0], w_ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = (r_cnt == '0);

    // a load with a nonzero iteration count always starts a run of at least one iteration
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_iters != '0) |=> !o_done)
        else $error("divider reported done right after a load");

endmodule

[rtl/fts_dpath.sv]
// Datapath: scale multiply, totals, step accumulator, fps and alpha division
`timescale 1ns / 1ps
module fts_dpath
    import fts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  t_in_item              i_in_item,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_item
);

    // configuration
    logic [PERIOD_W-1:0] r_period;
    logic [STEPS_W-1:0]  r_max_steps;

    // latched input
    logic [2:0]         r_op;
    logic [DELTA_W-1:0] r_delta;
    logic [SV_W-1:0]    r_sv;

    // architectural state
    logic [SCALE_W-1:0]  r_scale;
    logic [SCALE_W-1:0]  r_saved;
    logic [TOTAL_W-1:0]  r_real;
    logic [TOTAL_W-1:0]  r_game;
    logic [ACCUM_W-1:0]  r_accum;
    logic [FRAMES_W-1:0] r_frames;
    logic [ACCUM_W-1:0]  r_window;
    logic [FPS_W-1:0]    r_fps;

    // per-item working registers
    logic [PROD_W-1:0]   r_prod;
    logic [DELTA_W-1:0]  r_gd;
    logic [STEPS_W-1:0]  r_steps;
    logic [ALPHA_W-1:0]  r_alpha;
    logic                r_sat;

    // output register
    logic       r_out_valid;
    t_out_item  r_out;

    logic [PROD_W-1:0]            w_prod;
    logic [PROD_W-SCALE_FRAC_BITS-1:0] w_gd_wide;
    logic [DELTA_W-1:0]           w_gd;
    logic [ACCUM_W:0]             w_window_sum;
    logic [ACCUM_W:0]             w_accum_sum;
    logic [ACCUM_W-1:0]           w_period_ext;
    logic [FPS_NUM_W-1:0]         w_fps_num;
    logic                         w_div_load;
    logic [DIV_W-1:0]             w_div_rem0;
    logic [DIV_W-1:0]             w_div_den;
    logic [DIV_BITS-1:0]          w_div_bits;
    logic [DIV_CNT_W-1:0]         w_div_iters;
    logic [DIV_BITS-1:0]          w_div_quo;
    logic                         w_div_done;

    // scaled delta, saturated to 32 bits
    assign w_prod    = PROD_W'(r_delta) * PROD_W'(r_scale);
    assign w_gd_wide = r_prod[PROD_W-1:SCALE_FRAC_BITS];
    assign w_gd      = (|w_gd_wide[PROD_W-SCALE_FRAC_BITS-1:DELTA_W]) ? '1
                                                                    : w_gd_wide[DELTA_W-1:0];

    assign w_window_sum = {1'b0, r_window} + (ACCUM_W+1)'(r_delta);
    assign w_accum_sum  = {1'b0, r_accum} + (ACCUM_W+1)'(w_gd);
    assign w_period_ext = ACCUM_W'(r_period);
    assign w_fps_num    = FPS_NUM_W'(r_frames) << FPS_SHIFT;

    // divider operand select
    assign w_div_load = i_cmd.fps_load | i_cmd.alpha_load;
    always_comb begin
        if (i_cmd.fps_load) begin
            w_div_rem0  = w_fps_num[DIV_W-1:0];
            w_div_den   = r_window;
            w_div_bits  = '0;
            w_div_iters = DIV_CNT_W'(FPS_W);
        end else begin
            w_div_rem0  = r_accum >> ALPHA_SHIFT;
            w_div_den   = w_period_ext;
            w_div_bits  = {r_accum[ALPHA_SHIFT-1:0], (DIV_BITS-ALPHA_SHIFT)'(0)};
            w_div_iters = DIV_CNT_W'(ALPHA_W);
        end
    end

    fts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_div_load),
        .i_rem0  (w_div_rem0),
        .i_den   (w_div_den),
        .i_bits  (w_div_bits),
        .i_iters (w_div_iters),
        .o_quo   (w_div_quo),
        .o_done  (w_div_done)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PERIOD_RESET;
            r_max_steps <= MAX_STEPS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STEP_PERIOD: r_period    <= i_cfg_data[PERIOD_W-1:0];
                CFG_MAX_STEPS:   r_max_steps <= i_cfg_data[STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    // input capture and multiply
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_in_item.opcode;
            r_delta <= i_in_item.frame_delta;
            r_sv    <= i_in_item.scale_value;
        end
        if (i_cmd.exec) begin
            r_prod <= w_prod;
        end
    end

    // scale registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_ONE;
            r_saved <= SCALE_ONE;
        end else if (i_cmd.exec) begin
            unique case (r_op)
                OP_SCALE:  r_scale <= r_sv[SV_W-1] ? '0 : r_sv[SCALE_W-1:0];
                OP_PAUSE: begin
                    r_saved <= r_scale;
                    r_scale <= '0;
                end
                OP_RESUME: r_scale <= r_saved;
                default: ;
            endcase
        end
    end

    // totals, fps window and step accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real   <= '0;
            r_game   <= '0;
            r_accum  <= '0;
            r_frames <= '0;
            r_window <= '0;
            r_fps    <= '0;
        end else if (i_cmd.exec && r_op == OP_CLEAR) begin
            r_real   <= '0;
            r_game   <= '0;
            r_accum  <= '0;
            r_frames <= '0;
            r_window <= '0;
            r_fps    <= '0;
        end else if (i_cmd.acc) begin
            r_real   <= r_real + TOTAL_W'(r_delta);
            r_game   <= r_game + TOTAL_W'(w_gd);
            r_frames <= (r_frames == '1) ? r_frames : r_frames + FRAMES_W'(1);
            r_window <= w_window_sum[ACCUM_W] ? '1 : w_window_sum[ACCUM_W-1:0];
            r_accum  <= w_accum_sum[ACCUM_W] ? '1 : w_accum_sum[ACCUM_W-1:0];
        end else if (i_cmd.fps_wr) begin
            r_fps    <= r_sat ? '1 : w_div_quo;
            r_frames <= '0;
            r_window <= '0;
        end else if (i_cmd.step) begin
            r_accum  <= r_accum - w_period_ext;
        end
    end

    // per-item results
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_gd    <= '0;
            r_steps <= '0;
            r_alpha <= '0;
        end
        if (i_cmd.acc) begin
            r_gd <= w_gd;
        end
        if (i_cmd.step) begin
            r_steps <= r_steps + STEPS_W'(1);
        end
        if (i_cmd.alpha_wr) begin
            r_alpha <= r_sat ? '1 : w_div_quo[ALPHA_W-1:0];
        end
        // quotient overflow decided up front from the operands, before the division runs
        if (i_cmd.fps_load) begin
            r_sat <= w_fps_num >= FPS_NUM_W'(r_window);
        end else if (i_cmd.alpha_load) begin
            r_sat <= (r_period == '0) || (r_accum >= (w_period_ext << ALPHA_SHIFT));
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.step_count   <= r_steps;
            r_out.alpha        <= r_alpha;
            r_out.fps_value    <= r_fps;
            r_out.scaled_delta <= r_gd;
            r_out.real_total   <= r_real;
            r_out.game_total   <= r_game;
        end
    end

    // status to controller
    assign o_status.is_frame    = (r_op == OP_FRAME);
    assign o_status.window_full = (r_window >= WINDOW_ONE);
    assign o_status.step_go     = (r_steps < r_max_steps) && (r_accum >= w_period_ext);
    assign o_status.div_done    = w_div_done;
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // the step loop only runs with the fps window below one full window
    a_window_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_window < WINDOW_ONE))
        else $error("step issued with the fps window still full");

    // leftover is below one period unless the step limit stopped the loop or the period is zero
    a_leftover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.alpha_wr && r_steps < r_max_steps && r_period != '0)
            |-> (r_accum < w_period_ext))
        else $error("step loop left a full period in the accumulator");

endmodule

[rtl/fts_ctrl.sv]
// Controller: sequences one item through the datapath
`timescale 1ns / 1ps
module fts_ctrl
    import fts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_EXEC;
            S_EXEC:      n_state = i_status.is_frame ? S_ACC : S_DONE;
            S_ACC:       n_state = S_WINDOW;
            S_WINDOW:    n_state = i_status.window_full ? S_FPS_RUN : S_STEP;
            S_FPS_RUN:   if (i_status.div_done) n_state = S_STEP;
            S_STEP:      if (!i_status.step_go) n_state = S_ALPHA_RUN;
            S_ALPHA_RUN: if (i_status.div_done) n_state = S_DONE;
            S_DONE:      if (i_status.out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            S_EXEC:      o_cmd.exec = 1'b1;
            S_ACC:       o_cmd.acc = 1'b1;
            S_WINDOW:    o_cmd.fps_load = i_status.window_full;
            S_FPS_RUN:   o_cmd.fps_wr = i_status.div_done;
            S_STEP: begin
                o_cmd.step       = i_status.step_go;
                o_cmd.alpha_load = !i_status.step_go;
            end
            S_ALPHA_RUN: o_cmd.alpha_wr = i_status.div_done;
            S_DONE:      o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end

    // an accepted item always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("transfer accepted but controller stayed idle");

endmodule

[rtl/fixed_timestep_scheduler_core.sv]
// Top level of the fixed-timestep scheduler
`timescale 1ns / 1ps
// Takes one opcode item at a time and returns one result per item. A frame
// item divides for fps on the frames that close a one-second fps window,
// then issues one fixed step per period held in the accumulator (at most
// 15), then divides for alpha; set scale, pause, resume and reset counters
// skip these. The frame time is set by the step loop, which removes one
// period per cycle, and by the shared restoring divider, which gives one
// quotient bit per cycle (16 for alpha, 24 for fps). The result waits in
// an output register, so the next item can be taken while it is still
// held by the consumer. Configuration writes are always ready and must
// only be issued while no item is in progress.
module fixed_timestep_scheduler_core
    import fts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    // configuration is taken in any cycle
    assign o_cfg_ready = 1'b1;

    fts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    fts_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
